FILE: design/wfc_pkg.sv
// Shared types, constants and twiddle generation for the windowed FFT coefficient core.
`timescale 1ns / 1ps
`default_nettype none

package wfc_pkg;

    // Default sizing
    localparam int DEF_MAX_POINTS  = 64;
    localparam int DEF_SAMPLE_BITS = 16;

    // Fixed port widths
    localparam int POS_W      = 16;
    localparam int KEEP_W     = 7;
    localparam int COEF_W     = 32;
    localparam int INDEX_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_INDEX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT  = 2'd2;

    // Reset values
    localparam logic [POS_W-1:0]  RST_START_INDEX = 16'd0;
    localparam logic [POS_W-1:0]  RST_WINDOW_LEN  = 16'd64;
    localparam logic [KEEP_W-1:0] RST_KEEP_COUNT  = 7'd64;

    // Twiddle and scaling constants
    localparam int     TW_W          = 19;
    localparam int     TW_FRAC       = 17;
    localparam int     INV_SQRT2_Q17 = 92682;
    localparam longint TWO_PI_Q30    = 64'sd6746518852;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_EMPTY,
        ST_PAD,
        ST_REV,
        ST_REV_WA,
        ST_REV_WB,
        ST_BF,
        ST_BF_MC,
        ST_BF_MS,
        ST_BF_ADD,
        ST_BF_WA,
        ST_BF_WB,
        ST_OUT_RD,
        ST_OUT_MUL,
        ST_OUT_EMIT
    } state_t;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_SETUP,
        OP_EMPTY_EMIT,
        OP_PAD,
        OP_REV_INIT,
        OP_REV_SKIP,
        OP_REV_RD,
        OP_REV_WA,
        OP_REV_WB,
        OP_BF_INIT,
        OP_BF_RD,
        OP_MUL_COS,
        OP_MUL_SIN,
        OP_BF_ADD,
        OP_BF_WA,
        OP_BF_WB,
        OP_OUT_INIT,
        OP_OUT_RD,
        OP_OUT_MUL,
        OP_OUT_EMIT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic accept;
    } cmd_t;

    typedef struct packed {
        logic fill_zero;
        logic ptr_at_size;
        logic rev_swap;
        logic stage_done;
        logic out_last;
    } status_t;

    // Shift-subtract unsigned divide, elaboration use only
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            if (rem >= den)
            begin
                rem = rem - den;
                q   = q | (64'd1 << b);
            end
        end
        return q;
    endfunction

    // Taylor series in Q30, odd selects sine
    function automatic longint series_q30(input longint x, input bit odd);
        longint term;
        longint sum;
        longint n;
        bit     neg;
        term = odd ? x : (64'sd1 <<< 30);
        sum  = 0;
        n    = odd ? 1 : 0;
        neg  = 1'b0;
        while (term != 0 && n < 60)
        begin
            sum  = neg ? sum - term : sum + term;
            term = (term * x) >>> 30;
            term = longint'(udiv64(longint'(term), longint'((n + 1) * (n + 2))));
            n    = n + 2;
            neg  = !neg;
        end
        return sum;
    endfunction

    // Twiddle entry k of a 2^log2cap point table, Q1.17
    function automatic longint twiddle_q17(input int k, input int log2cap, input bit want_sin);
        longint cap;
        longint kk;
        bit     flip;
        longint ang;
        longint c;
        longint s;
        cap  = 64'sd1 <<< log2cap;
        kk   = k;
        flip = 1'b0;
        if (4 * longint'(k) > cap)
        begin
            kk   = (cap >>> 1) - k;
            flip = 1'b1;
        end
        ang = (TWO_PI_Q30 * kk + (cap >>> 1)) >>> log2cap;
        c   = (series_q30(ang, 1'b0) + 64'sd4096) >>> 13;
        s   = (series_q30(ang, 1'b1) + 64'sd4096) >>> 13;
        if (want_sin)
            return s;
        return flip ? -c : c;
    endfunction

endpackage

`default_nettype wire

FILE: design/wfc_ctrl.sv
// Sequencer for loading, padding, reordering, butterflies and coefficient output.
`timescale 1ns / 1ps
`default_nettype none

module wfc_ctrl
    import wfc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire logic    last_sample,
    input  wire status_t status,
    output cmd_t         cmd,
    output logic         busy
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.accept = 1'b0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy       = 1'b0;
                cmd.accept = start;
                if (start && last_sample)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                cmd.op     = OP_SETUP;
                state_next = status.fill_zero ? ST_EMPTY : ST_PAD;
            end
            ST_EMPTY:
            begin
                cmd.op     = OP_EMPTY_EMIT;
                state_next = ST_IDLE;
            end
            ST_PAD:
            begin
                if (status.ptr_at_size)
                begin
                    cmd.op     = OP_REV_INIT;
                    state_next = ST_REV;
                end
                else
                    cmd.op = OP_PAD;
            end
            ST_REV:
            begin
                if (status.ptr_at_size)
                begin
                    cmd.op     = OP_BF_INIT;
                    state_next = ST_BF;
                end
                else if (status.rev_swap)
                begin
                    cmd.op     = OP_REV_RD;
                    state_next = ST_REV_WA;
                end
                else
                    cmd.op = OP_REV_SKIP;
            end
            ST_REV_WA:
            begin
                cmd.op     = OP_REV_WA;
                state_next = ST_REV_WB;
            end
            ST_REV_WB:
            begin
                cmd.op     = OP_REV_WB;
                state_next = ST_REV;
            end
            ST_BF:
            begin
                if (status.stage_done)
                begin
                    cmd.op     = OP_OUT_INIT;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    cmd.op     = OP_BF_RD;
                    state_next = ST_BF_MC;
                end
            end
            ST_BF_MC:
            begin
                cmd.op     = OP_MUL_COS;
                state_next = ST_BF_MS;
            end
            ST_BF_MS:
            begin
                cmd.op     = OP_MUL_SIN;
                state_next = ST_BF_ADD;
            end
            ST_BF_ADD:
            begin
                cmd.op     = OP_BF_ADD;
                state_next = ST_BF_WA;
            end
            ST_BF_WA:
            begin
                cmd.op     = OP_BF_WA;
                state_next = ST_BF_WB;
            end
            ST_BF_WB:
            begin
                cmd.op     = OP_BF_WB;
                state_next = ST_BF;
            end
            ST_OUT_RD:
            begin
                cmd.op     = OP_OUT_RD;
                state_next = ST_OUT_MUL;
            end
            ST_OUT_MUL:
            begin
                cmd.op     = OP_OUT_MUL;
                state_next = ST_OUT_EMIT;
            end
            ST_OUT_EMIT:
            begin
                cmd.op     = OP_OUT_EMIT;
                state_next = status.out_last ? ST_IDLE : ST_OUT_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/wfc_datapath.sv
// Work memory, counters, twiddle tables, shared multipliers and output scaling.
`timescale 1ns / 1ps
`default_nettype none

module wfc_datapath
    import wfc_pkg::*;
#(
    parameter int MAX_POINTS  = DEF_MAX_POINTS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cmd_t                          cmd,
    input  wire logic [POS_W-1:0]              start_index,
    input  wire logic [POS_W-1:0]              window_len,
    input  wire logic [KEEP_W-1:0]             keep_count,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic                          last_sample,
    output status_t                            status,
    output logic signed [COEF_W-1:0]           coef_real,
    output logic signed [COEF_W-1:0]           coef_imag,
    output logic [INDEX_W-1:0]                 coef_index,
    output logic                               last_coef,
    output logic                               coef_valid
);

    localparam int LOG2CAP = ((1 << $clog2(MAX_POINTS)) == MAX_POINTS) ?
                             $clog2(MAX_POINTS) : $clog2(MAX_POINTS) - 1;
    localparam int AW   = LOG2CAP;
    localparam int FW   = AW + 1;
    localparam int CAP  = 1 << AW;
    localparam int WW   = SAMPLE_BITS + 8 + AW + 2;
    localparam int PW   = WW + TW_W;
    localparam int KW   = $clog2(AW + 1);
    localparam int SHW  = $clog2(TW_FRAC + AW + 2) + 1;
    localparam int TWN  = CAP / 2;
    localparam int TIW  = (AW > 1) ? AW - 1 : 1;
    localparam int CW   = (KEEP_W > FW) ? KEEP_W : FW;
    localparam logic signed [PW:0] SAT_HI = (PW + 1)'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [PW:0] SAT_LO = (PW + 1)'(-64'sh0000_0000_8000_0000);
    localparam logic signed [PW:0] TW_RND = (PW + 1)'(64'sd1 <<< (TW_FRAC - 1));

    // Twiddle tables, constant logic
    logic signed [TW_W-1:0] cos_rom [TWN];
    logic signed [TW_W-1:0] sin_rom [TWN];
    for (genvar g = 0; g < TWN; g++)
    begin : g_tw
        assign cos_rom[g] = TW_W'(twiddle_q17(g, LOG2CAP, 1'b0));
        assign sin_rom[g] = TW_W'(twiddle_q17(g, LOG2CAP, 1'b1));
    end

    // Work memory, {real, imag}
    logic [2*WW-1:0] work_mem [CAP];

    logic [POS_W-1:0]      pos_reg;
    logic [FW-1:0]         fill_reg;
    logic [KW-1:0]         k_reg;
    logic [FW-1:0]         cnt_reg;
    logic [FW-1:0]         ptr_reg;
    logic [KW-1:0]         stage_reg;
    logic [2*WW-1:0]       rd_a_reg;
    logic [2*WW-1:0]       rd_b_reg;
    logic signed [TW_W-1:0] twc_reg;
    logic signed [TW_W-1:0] tws_reg;
    logic signed [PW-1:0]  pa_x_reg;
    logic signed [PW-1:0]  pa_y_reg;
    logic signed [PW-1:0]  pb_x_reg;
    logic signed [PW-1:0]  pb_y_reg;
    logic signed [WW-1:0]  t_re_reg;
    logic signed [WW-1:0]  t_im_reg;
    logic signed [COEF_W-1:0] coef_real_reg;
    logic signed [COEF_W-1:0] coef_imag_reg;
    logic [INDEX_W-1:0]    coef_index_reg;
    logic                  last_coef_reg;
    logic                  coef_valid_reg;

    // Window capture test
    logic [POS_W-1:0] pos_off;
    logic             in_win;
    assign pos_off = pos_reg - start_index;
    assign in_win  = (pos_reg >= start_index) && (pos_off < window_len) &&
                     (fill_reg < FW'(CAP));

    // Transform size from fill: smallest power of two covering it
    logic [KW-1:0] k_fill;
    logic [FW-1:0] size_fill;
    always_comb
    begin
        k_fill = '0;
        for (int b = 0; b < AW; b++)
        begin
            if ((FW'(1) << b) < fill_reg)
                k_fill = KW'(b + 1);
        end
    end
    assign size_fill = FW'(1) << k_fill;

    // Number of bins to emit
    logic [CW-1:0] cnt_comb;
    always_comb
    begin
        cnt_comb = (keep_count == '0) ? CW'(1) : CW'(keep_count);
        if (window_len <= POS_W'(keep_count))
            cnt_comb = CW'(fill_reg);
        if (cnt_comb > CW'(size_fill))
            cnt_comb = CW'(size_fill);
    end

    logic [FW-1:0] size;
    logic [FW-1:0] half_size;
    logic [AW-1:0] ptr_lo;
    assign size      = FW'(1) << k_reg;
    assign half_size = size >> 1;
    assign ptr_lo    = ptr_reg[AW-1:0];

    // Bit-reversed partner for the reorder pass
    logic [AW-1:0] rev_full;
    logic [AW-1:0] rev_idx;
    always_comb
    begin
        for (int b = 0; b < AW; b++)
            rev_full[b] = ptr_lo[AW-1-b];
    end
    assign rev_idx = rev_full >> (KW'(AW) - k_reg);

    // Butterfly addressing: ptr counts butterflies within the stage
    logic [AW-1:0] bf_half;
    logic [AW-1:0] bf_j;
    logic [AW-1:0] bf_grp;
    logic [AW-1:0] bf_ia;
    logic [AW-1:0] bf_ib;
    logic [AW-1:0] tw_full;
    logic [TIW-1:0] tw_idx;
    assign bf_half = AW'(1) << stage_reg;
    assign bf_j    = ptr_lo & (bf_half - AW'(1));
    assign bf_grp  = ptr_lo >> stage_reg;
    assign bf_ia   = (bf_grp << (stage_reg + KW'(1))) | bf_j;
    assign bf_ib   = bf_ia | bf_half;
    assign tw_full = bf_j << (KW'(AW - 1) - stage_reg);
    assign tw_idx  = tw_full[TIW-1:0];

    logic bf_last;
    assign bf_last = (ptr_reg == half_size - FW'(1));

    // Status to the controller
    assign status.fill_zero   = (fill_reg == '0);
    assign status.ptr_at_size = (ptr_reg == size);
    assign status.rev_swap    = (ptr_lo < rev_idx);
    assign status.stage_done  = (stage_reg == k_reg);
    assign status.out_last    = (ptr_reg == cnt_reg - FW'(1));

    // Operand views
    logic signed [WW-1:0] a_re;
    logic signed [WW-1:0] a_im;
    logic signed [WW-1:0] b_re;
    logic signed [WW-1:0] b_im;
    logic signed [WW-1:0] load_val;
    assign a_re     = rd_a_reg[2*WW-1 -: WW];
    assign a_im     = rd_a_reg[WW-1:0];
    assign b_re     = rd_b_reg[2*WW-1 -: WW];
    assign b_im     = rd_b_reg[WW-1:0];
    assign load_val = WW'($signed({sample, 8'b0}));

    // Memory port control
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [2*WW-1:0] mem_wd;
    logic            mem_re;
    logic [AW-1:0]   mem_ra_a;
    logic [AW-1:0]   mem_ra_b;
    always_comb
    begin
        mem_we   = 1'b0;
        mem_wa   = '0;
        mem_wd   = '0;
        mem_re   = 1'b0;
        mem_ra_a = '0;
        mem_ra_b = '0;
        if (cmd.accept && in_win)
        begin
            mem_we = 1'b1;
            mem_wa = fill_reg[AW-1:0];
            mem_wd = {$signed(load_val), {WW{1'b0}}};
        end
        unique case (cmd.op)
            OP_PAD:
            begin
                mem_we = 1'b1;
                mem_wa = ptr_lo;
            end
            OP_REV_RD:
            begin
                mem_re   = 1'b1;
                mem_ra_a = ptr_lo;
                mem_ra_b = rev_idx;
            end
            OP_REV_WA:
            begin
                mem_we = 1'b1;
                mem_wa = ptr_lo;
                mem_wd = rd_b_reg;
            end
            OP_REV_WB:
            begin
                mem_we = 1'b1;
                mem_wa = rev_idx;
                mem_wd = rd_a_reg;
            end
            OP_BF_RD:
            begin
                mem_re   = 1'b1;
                mem_ra_a = bf_ia;
                mem_ra_b = bf_ib;
            end
            OP_BF_WA:
            begin
                mem_we = 1'b1;
                mem_wa = bf_ia;
                mem_wd = {a_re + t_re_reg, a_im + t_im_reg};
            end
            OP_BF_WB:
            begin
                mem_we = 1'b1;
                mem_wa = bf_ib;
                mem_wd = {a_re - t_re_reg, a_im - t_im_reg};
            end
            OP_OUT_RD:
            begin
                mem_re   = 1'b1;
                mem_ra_b = ptr_lo;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    // Work memory, one write port and two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
            work_mem[mem_wa] <= mem_wd;
        if (mem_re)
        begin
            rd_a_reg <= work_mem[mem_ra_a];
            rd_b_reg <= work_mem[mem_ra_b];
        end
    end

    // Shared multiplier pair
    logic signed [TW_W-1:0] mul_coef;
    logic signed [PW-1:0]   mul_x;
    logic signed [PW-1:0]   mul_y;
    always_comb
    begin
        case (cmd.op)
            OP_MUL_SIN: mul_coef = tws_reg;
            OP_OUT_MUL: mul_coef = TW_W'(INV_SQRT2_Q17);
            default:    mul_coef = twc_reg;
        endcase
    end
    assign mul_x = PW'(mul_coef) * PW'(b_re);
    assign mul_y = PW'(mul_coef) * PW'(b_im);

    // Twiddle product sums, rounded back to work precision
    logic signed [PW:0] sum_re;
    logic signed [PW:0] sum_im;
    logic signed [PW:0] sh_re;
    logic signed [PW:0] sh_im;
    assign sum_re = (PW + 1)'(pa_x_reg) + (PW + 1)'(pb_y_reg) + TW_RND;
    assign sum_im = (PW + 1)'(pa_y_reg) - (PW + 1)'(pb_x_reg) + TW_RND;
    assign sh_re  = sum_re >>> TW_FRAC;
    assign sh_im  = sum_im >>> TW_FRAC;

    // Final scaling: rounded shift and saturation
    function automatic logic signed [COEF_W-1:0] scale_sat(input logic signed [PW-1:0] x,
                                                           input logic [SHW-1:0] s);
        logic signed [PW:0] rnd;
        logic signed [PW:0] sh;
        rnd = (PW + 1)'(x) + $signed((PW + 1)'(1) << (s - SHW'(1)));
        sh  = rnd >>> s;
        if (sh > SAT_HI)
            return COEF_W'(SAT_HI);
        if (sh < SAT_LO)
            return COEF_W'(SAT_LO);
        return COEF_W'(sh);
    endfunction

    // With 2*size = 2^(k+1): odd k shifts the bin, even k goes through 1/sqrt2
    logic [SHW-1:0]       scl_shift;
    logic signed [PW-1:0] scl_re;
    logic signed [PW-1:0] scl_im;
    always_comb
    begin
        if (k_reg[0])
        begin
            scl_shift = SHW'((k_reg + KW'(1)) >> 1);
            scl_re    = PW'(b_re);
            scl_im    = PW'(b_im);
        end
        else
        begin
            scl_shift = SHW'(TW_FRAC) + SHW'(k_reg >> 1);
            scl_re    = pa_x_reg;
            scl_im    = pa_y_reg;
        end
    end

    // Series position and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (last_sample)
                    pos_reg <= '0;
                else if (pos_reg != '1)
                    pos_reg <= pos_reg + POS_W'(1);
                if (in_win)
                    fill_reg <= fill_reg + FW'(1);
            end
            if (cmd.op == OP_EMPTY_EMIT || (cmd.op == OP_OUT_EMIT && status.out_last))
                fill_reg <= '0;
        end
    end

    // Sequencing counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            cnt_reg   <= '0;
            ptr_reg   <= '0;
            stage_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_SETUP:
                begin
                    k_reg   <= k_fill;
                    cnt_reg <= FW'(cnt_comb);
                    ptr_reg <= fill_reg;
                end
                OP_PAD, OP_REV_SKIP, OP_REV_WB, OP_OUT_EMIT:
                    ptr_reg <= ptr_reg + FW'(1);
                OP_REV_INIT, OP_OUT_INIT:
                    ptr_reg <= '0;
                OP_BF_INIT:
                begin
                    ptr_reg   <= '0;
                    stage_reg <= '0;
                end
                OP_BF_WB:
                begin
                    if (bf_last)
                    begin
                        ptr_reg   <= '0;
                        stage_reg <= stage_reg + KW'(1);
                    end
                    else
                        ptr_reg <= ptr_reg + FW'(1);
                end
                default:
                begin
                    ptr_reg <= ptr_reg;
                end
            endcase
        end
    end

    // Twiddles, products and butterfly offsets
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_BF_RD:
            begin
                twc_reg <= cos_rom[tw_idx];
                tws_reg <= sin_rom[tw_idx];
            end
            OP_MUL_COS, OP_OUT_MUL:
            begin
                pa_x_reg <= mul_x;
                pa_y_reg <= mul_y;
            end
            OP_MUL_SIN:
            begin
                pb_x_reg <= mul_x;
                pb_y_reg <= mul_y;
            end
            OP_BF_ADD:
            begin
                t_re_reg <= WW'(sh_re);
                t_im_reg <= WW'(sh_im);
            end
            default:
            begin
                t_re_reg <= t_re_reg;
            end
        endcase
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_EMPTY_EMIT)
        begin
            coef_real_reg  <= '0;
            coef_imag_reg  <= '0;
            coef_index_reg <= '0;
            last_coef_reg  <= 1'b1;
        end
        else if (cmd.op == OP_OUT_EMIT)
        begin
            coef_real_reg  <= scale_sat(scl_re, scl_shift);
            coef_imag_reg  <= scale_sat(scl_im, scl_shift);
            coef_index_reg <= INDEX_W'(ptr_reg);
            last_coef_reg  <= status.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coef_valid_reg <= 1'b0;
        else
            coef_valid_reg <= (cmd.op == OP_EMPTY_EMIT) || (cmd.op == OP_OUT_EMIT);
    end

    assign coef_real  = coef_real_reg;
    assign coef_imag  = coef_imag_reg;
    assign coef_index = coef_index_reg;
    assign last_coef  = last_coef_reg;
    assign coef_valid = coef_valid_reg;

endmodule

`default_nettype wire

FILE: design/windowed_fft_coefficients_core.sv
// Top level: configuration registers, sequencer and datapath of the windowed FFT core.
//
//  channel   handshake          payload
//  samples   start / busy       sample, last_sample
//  results   coef_valid         coef_real, coef_imag, coef_index, last_coef
//  config    cfg_write          cfg_index, cfg_data
//
// Samples are taken one per cycle while busy is low. The sample with last_sample set
// starts the run: a setup step, padding up to N, one reorder step per index plus the
// write steps of each swapped pair, (N/2)*log2(N) butterflies on the single write port
// of the work memory and a closing step, then a read, scale and emit sequence per bin
// (N = padded size). An empty window gives one zero result after the last sample.
// Reset is asynchronous and clears control state; results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module windowed_fft_coefficients_core
    import wfc_pkg::*;
#(
    parameter int MAX_POINTS  = DEF_MAX_POINTS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic                          last_sample,
    output logic                               coef_valid,
    output logic signed [COEF_W-1:0]           coef_real,
    output logic signed [COEF_W-1:0]           coef_imag,
    output logic [INDEX_W-1:0]                 coef_index,
    output logic                               last_coef
);

    logic [POS_W-1:0]  start_index_reg;
    logic [POS_W-1:0]  window_len_reg;
    logic [KEEP_W-1:0] keep_count_reg;
    cmd_t              cmd;
    status_t           status;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_index_reg <= RST_START_INDEX;
            window_len_reg  <= RST_WINDOW_LEN;
            keep_count_reg  <= RST_KEEP_COUNT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_START_INDEX: start_index_reg <= cfg_data;
                REG_WINDOW_LEN:  window_len_reg  <= cfg_data;
                REG_KEEP_COUNT:  keep_count_reg  <= cfg_data[KEEP_W-1:0];
                default:         keep_count_reg  <= keep_count_reg;
            endcase
        end
    end

    wfc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .last_sample (last_sample),
        .status      (status),
        .cmd         (cmd),
        .busy        (busy)
    );

    wfc_datapath #(
        .MAX_POINTS  (MAX_POINTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .start_index (start_index_reg),
        .window_len  (window_len_reg),
        .keep_count  (keep_count_reg),
        .sample      (sample),
        .last_sample (last_sample),
        .status      (status),
        .coef_real   (coef_real),
        .coef_imag   (coef_imag),
        .coef_index  (coef_index),
        .last_coef   (last_coef),
        .coef_valid  (coef_valid)
    );

`ifndef ASSERT_OFF
    // A closing sample starts the transform
    a_last_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last_sample |=> busy)
        else $error("run did not start after last sample");

    // The final coefficient leaves the core idle
    a_last_coef_idle: assert property (@(posedge clk) disable iff (!rst_n)
        coef_valid && last_coef |-> !busy)
        else $error("core still busy on final coefficient");

    // Results never come in adjacent cycles
    a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        coef_valid |=> !coef_valid)
        else $error("back-to-back result transactions");

    // No result while a series is being loaded
    a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !$past(busy) && $past(!coef_valid) |-> !coef_valid)
        else $error("result transaction during loading");
`endif

endmodule

`default_nettype wire
